// ----- hw/rtl/fstf_pkg.sv -----
package fstf_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_FMT = 2'd0;
    localparam logic [1:0] KIND_NUM = 2'd1;
    localparam logic [1:0] KIND_STR = 2'd2;

    // Formatter phase codes
    localparam logic [1:0] PH_TEXT    = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_ARG     = 2'd2;
    localparam logic [1:0] PH_UNUSED  = 2'd3;

    // Pending specifier codes
    localparam logic [1:0] SP_UNSIGNED = 2'd0;
    localparam logic [1:0] SP_SIGNED   = 2'd1;
    localparam logic [1:0] SP_CHAR     = 2'd2;
    localparam logic [1:0] SP_STRING   = 2'd3;

    // Character constants
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_S   = 8'h73;
    localparam logic [7:0] CH_LOW_U   = 8'h75;

    localparam int TAB_STOP = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_in;
        logic [31:0] arg_value;
        logic        arg_null;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       is_last;
    } out_item_t;

    // Commands to the shared conversion unit
    typedef struct packed {
        logic load;   // take a new binary magnitude, clear the digits
        logic step;   // one shift-add-3 conversion step
        logic shift;  // drop the leading digit
    } bcd_ctrl_t;

endpackage

// ----- hw/rtl/fstf_bcd_unit.sv -----
module fstf_bcd_unit #(
    parameter int ARG_WIDTH  = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                   aclk,
    input  fstf_pkg::bcd_ctrl_t    ctrl,
    input  logic [ARG_WIDTH-1:0]   load_value,
    output logic [3:0]             top_digit
);
    import fstf_pkg::*;

    localparam int BCD_WIDTH = 4 * NUM_DIGITS;

    logic [ARG_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_WIDTH-1:0] bcd_reg, bcd_next;
    logic [BCD_WIDTH-1:0] bcd_adj;

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load) begin
            bin_next = load_value;
            bcd_next = '0;
        end else if (ctrl.step) begin
            bin_next = {bin_reg[ARG_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[ARG_WIDTH-1]};
        end else if (ctrl.shift) begin
            bcd_next = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

endmodule

// ----- hw/rtl/fstf_out_reg.sv -----
module fstf_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  fstf_pkg::out_item_t load_data,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output fstf_pkg::out_item_t m_data
);
    import fstf_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;

    // Room for a new character when empty or when the held one leaves now
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- hw/rtl/format_string_text_formatter.sv -----
// printf-style text formatter.
// Input channel s_valid/s_ready/s_data carries format bytes, numeric or char
// arguments and string-argument bytes; output channel m_valid/m_ready/m_data
// carries one emitted character per transfer, is_last marking the terminator.
// A character produced by an input transfer is loaded into the output register
// at the end of that cycle and is offered on m_valid in the cycle after it.
// Text bytes, %c, string bytes and the terminator go at one item per cycle when
// the receiver keeps up. A tab emits 1 to 4 spaces, up to the next tab stop.
// A %d or %u argument is converted in the shared shift-add-3 unit, one step per
// argument bit, then one digit position of the BCD register (NUM_DIGITS, 10 at
// the default width) at a time, an optional '-' going out in the transfer cycle.
// s_ready is low while a tab, a conversion or a digit stream is under way,
// and also whenever the output register is full and m_ready is low.
// A receiver stall holds the output character; tab spaces and digits wait for
// room, while the conversion steps and leading-zero skips run on.
// Reset (aresetn low, synchronous) empties the output register and returns
// to normal text at column zero.
module format_string_text_formatter #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fstf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fstf_pkg::out_item_t m_data
);
    import fstf_pkg::*;

    // Decimal digits needed for an ARG_WIDTH-bit magnitude (log10(2) ~ 0.302)
    localparam int NUM_DIGITS = (ARG_WIDTH * 302) / 1000 + 1;
    localparam int CCW        = $clog2(ARG_WIDTH);
    localparam int DCW        = $clog2(NUM_DIGITS + 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TAB    = 2'd1;
    localparam logic [1:0] S_CONV   = 2'd2;
    localparam logic [1:0] S_DIGITS = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [1:0]     phase_reg, phase_next;
    logic [1:0]     spec_reg, spec_next;
    logic [1:0]     column_reg, column_next;
    logic [1:0]     tab_cnt_reg, tab_cnt_next;
    logic [CCW-1:0] conv_cnt_reg, conv_cnt_next;
    logic [DCW-1:0] dig_cnt_reg, dig_cnt_next;
    logic           started_reg, started_next;

    logic           out_free;
    logic           out_load;
    out_item_t      out_item;
    logic           s_accept;

    bcd_ctrl_t            bcd_ctrl;
    logic [3:0]           top_digit;
    logic [63:0]          arg_ext;
    logic [ARG_WIDTH-1:0] mag_in;
    logic [ARG_WIDTH-1:0] mag_neg;
    logic                 is_neg;
    logic [ARG_WIDTH-1:0] load_value;

    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;

    // Argument magnitude at ARG_WIDTH bits: the word is 32 bits wide,
    // zero-extend above and truncate below as the width asks
    assign arg_ext    = {32'd0, s_data.arg_value};
    assign mag_in     = arg_ext[ARG_WIDTH-1:0];
    assign mag_neg    = ~mag_in + {{(ARG_WIDTH-1){1'b0}}, 1'b1};
    assign is_neg     = (spec_reg == SP_SIGNED) && mag_in[ARG_WIDTH-1];
    assign load_value = is_neg ? mag_neg : mag_in;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        spec_next     = spec_reg;
        column_next   = column_reg;
        tab_cnt_next  = tab_cnt_reg;
        conv_cnt_next = conv_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        started_next  = started_reg;
        out_load      = 1'b0;
        out_item      = '{char_out: CH_NUL, is_last: 1'b0};
        bcd_ctrl      = '{load: 1'b0, step: 1'b0, shift: 1'b0};

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (phase_reg == PH_ARG && spec_reg == SP_STRING) begin
                        // String argument: pass bytes until zero; a null emits a space and ends it
                        if (s_data.kind == KIND_STR) begin
                            if (s_data.arg_null) begin
                                out_load   = 1'b1;
                                out_item   = '{char_out: CH_SPACE, is_last: 1'b0};
                                phase_next = PH_TEXT;
                            end else if (s_data.char_in == CH_NUL) begin
                                phase_next = PH_TEXT;
                            end else begin
                                out_load = 1'b1;
                                out_item = '{char_out: s_data.char_in, is_last: 1'b0};
                            end
                        end
                    end else if (phase_reg == PH_ARG) begin
                        if (s_data.kind == KIND_NUM) begin
                            phase_next = PH_TEXT;
                            spec_next  = SP_UNSIGNED;
                            if (spec_reg == SP_CHAR) begin
                                out_load = 1'b1;
                                out_item = '{char_out: s_data.arg_value[7:0],
                                             is_last: 1'b0};
                            end else begin
                                // Emit the sign now, convert the magnitude
                                out_load      = is_neg;
                                out_item      = '{char_out: CH_MINUS, is_last: 1'b0};
                                bcd_ctrl.load = 1'b1;
                                conv_cnt_next = '0;
                                state_next    = S_CONV;
                            end
                        end
                    end else if (s_data.kind == KIND_FMT) begin
                        if (s_data.char_in == CH_NUL) begin
                            // Terminator: emit it and restart at column zero
                            out_load   = 1'b1;
                            out_item   = '{char_out: CH_NUL, is_last: 1'b1};
                            phase_next = PH_TEXT;
                            spec_next  = SP_UNSIGNED;
                        end else if (phase_reg == PH_PERCENT) begin
                            phase_next = PH_ARG;
                            case (s_data.char_in)
                                CH_LOW_D: spec_next = SP_SIGNED;
                                CH_LOW_U: spec_next = SP_UNSIGNED;
                                CH_LOW_C: spec_next = SP_CHAR;
                                CH_LOW_S: spec_next = SP_STRING;
                                default: begin
                                    // Unknown specifier: drop it
                                    phase_next = PH_TEXT;
                                    spec_next  = SP_UNSIGNED;
                                end
                            endcase
                        end else if (s_data.char_in == CH_PERCENT) begin
                            phase_next = PH_PERCENT;
                        end else if (s_data.char_in == CH_TAB) begin
                            // First space now, the rest up to the tab stop after
                            out_load     = 1'b1;
                            out_item     = '{char_out: CH_SPACE, is_last: 1'b0};
                            tab_cnt_next = ~column_reg;
                            if (column_reg != 2'(TAB_STOP - 1)) begin
                                state_next = S_TAB;
                            end
                        end else begin
                            out_load = 1'b1;
                            out_item = '{char_out: s_data.char_in, is_last: 1'b0};
                        end
                    end
                end
            end
            S_TAB: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_item     = '{char_out: CH_SPACE, is_last: 1'b0};
                    tab_cnt_next = tab_cnt_reg - 2'd1;
                    if (tab_cnt_reg == 2'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CONV: begin
                bcd_ctrl.step = 1'b1;
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == CCW'(ARG_WIDTH - 1)) begin
                    dig_cnt_next = DCW'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (!started_reg && top_digit == 4'd0 && dig_cnt_reg != DCW'(1)) begin
                    // Skip a leading zero
                    bcd_ctrl.shift = 1'b1;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                end else if (out_free) begin
                    out_load       = 1'b1;
                    out_item       = '{char_out: CH_ZERO + {4'd0, top_digit},
                                       is_last: 1'b0};
                    bcd_ctrl.shift = 1'b1;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    started_next   = 1'b1;
                    if (dig_cnt_reg == DCW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Column counts every emitted character; the terminator clears it
        if (out_load) begin
            column_next = out_item.is_last ? 2'd0 : column_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_TEXT;
            spec_reg     <= SP_UNSIGNED;
            column_reg   <= 2'd0;
            tab_cnt_reg  <= 2'd0;
            conv_cnt_reg <= '0;
            dig_cnt_reg  <= '0;
            started_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            spec_reg     <= spec_next;
            column_reg   <= column_next;
            tab_cnt_reg  <= tab_cnt_next;
            conv_cnt_reg <= conv_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            started_reg  <= started_next;
        end
    end

    fstf_bcd_unit #(
        .ARG_WIDTH  (ARG_WIDTH),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .aclk       (aclk),
        .ctrl       (bcd_ctrl),
        .load_value (load_value),
        .top_digit  (top_digit)
    );

    fstf_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_item),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // No character may be produced while the conversion unit is stepping
    a_conv_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CONV) |-> !out_load)
        else $error("character produced during conversion");

    // An accepted terminator returns the formatter to text at column zero
    a_term_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.kind == KIND_FMT && s_data.char_in == CH_NUL
         && phase_reg != PH_ARG)
        |=> (phase_reg == PH_TEXT && column_reg == 2'd0))
        else $error("terminator did not reset formatter state");

    // The digit stream always has a digit position left
    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIGITS) |-> (dig_cnt_reg != '0))
        else $error("digit stream ran past its last position");

    // The unused phase code is never reached
    a_phase_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_UNUSED)
        else $error("unused phase reached");
`endif

endmodule

// ----- bench/fstf_text_checker.sv -----
module fstf_text_checker
    import fstf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0] phase_q;
    logic [1:0] spec_q;
    logic [1:0] column_q;
    out_item_t  expected_chars[$];

    task automatic emit_char(logic [7:0] c);
        out_item_t o;
        o.char_out = c;
        o.is_last  = 1'b0;
        expected_chars.push_back(o);
        column_q = column_q + 2'd1;
    endtask

    task automatic emit_decimal(logic [31:0] word, logic is_signed);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        mag = word;
        // magnitude of the most negative value still fits as unsigned
        if (is_signed && mag[31]) begin
            emit_char(CH_MINUS);
            mag = ~mag + 32'd1;
        end
        do begin
            digits.push_front(CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        foreach (digits[i]) emit_char(digits[i]);
    endtask

    task automatic predict_text(in_item_t it);
        out_item_t term;
        int        spaces;
        if (phase_q == PH_ARG) begin
            if (spec_q == SP_STRING) begin
                if (it.kind != KIND_STR) return;
                if (it.arg_null) begin
                    emit_char(CH_SPACE);
                    phase_q = PH_TEXT;
                end else if (it.char_in == CH_NUL) begin
                    phase_q = PH_TEXT;
                end else begin
                    emit_char(it.char_in);
                end
                return;
            end
            if (it.kind != KIND_NUM) return;
            if (spec_q == SP_CHAR) emit_char(it.arg_value[7:0]);
            else emit_decimal(it.arg_value, spec_q == SP_SIGNED);
            phase_q = PH_TEXT;
            spec_q  = SP_UNSIGNED;
            return;
        end

        if (it.kind != KIND_FMT) return;

        if (it.char_in == CH_NUL) begin
            term.char_out = CH_NUL;
            term.is_last  = 1'b1;
            expected_chars.push_back(term);
            phase_q  = PH_TEXT;
            spec_q   = SP_UNSIGNED;
            column_q = 2'd0;
            return;
        end

        if (phase_q == PH_PERCENT) begin
            phase_q = PH_ARG;
            case (it.char_in)
                CH_LOW_D: spec_q = SP_SIGNED;
                CH_LOW_U: spec_q = SP_UNSIGNED;
                CH_LOW_C: spec_q = SP_CHAR;
                CH_LOW_S: spec_q = SP_STRING;
                default: begin
                    phase_q = PH_TEXT;
                    spec_q  = SP_UNSIGNED;
                end
            endcase
            return;
        end

        if (it.char_in == CH_PERCENT) begin
            phase_q = PH_PERCENT;
        end else if (it.char_in == CH_TAB) begin
            spaces = TAB_STOP - int'(column_q);
            repeat (spaces) emit_char(CH_SPACE);
        end else begin
            emit_char(it.char_in);
        end
    endtask

    task automatic check_char(out_item_t got);
        out_item_t want;
        if (expected_chars.size() == 0) begin
            $error("unexpected character %h (is_last %0b)", got.char_out, got.is_last);
            fail_count++;
            return;
        end
        want = expected_chars.pop_front();
        if (got.char_out !== want.char_out) begin
            $error("char_out expected %h got %h", want.char_out, got.char_out);
            fail_count++;
        end
        if (got.is_last !== want.is_last) begin
            $error("is_last expected %0b got %0b", want.is_last, got.is_last);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_q  = PH_TEXT;
            spec_q   = SP_UNSIGNED;
            column_q = 2'd0;
            expected_chars.delete();
        end else begin
            if (s_valid && s_ready) predict_text(s_data);
            if (m_valid && m_ready) check_char(m_data);
        end
        outstanding = expected_chars.size();
    end

endmodule

// ----- bench/format_string_text_formatter_tb.sv -----
module format_string_text_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fstf_pkg::*;

    localparam int ARG_WIDTH  = 32;
    localparam int TEXT_ITEMS = 270;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int fail_count;
    int outstanding;
    int sent_items;
    bit steady;     // when set, both sides run with no idle cycles

    format_string_text_formatter #(
        .ARG_WIDTH(ARG_WIDTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Prediction and comparison live in the checker; the top only drives.
    fstf_text_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop, far above the slowest legal run: every item at eleven
    // characters, each one held through a long receiver stall.
    initial begin
        #15_000_000;
        $display("format_string_text_formatter_tb: errors");
        $finish;
    end

    // Fields a given kind does not use are still randomized, so every input
    // bit toggles and the block is shown to ignore them.
    function automatic in_item_t fmt_byte(logic [7:0] c);
        in_item_t it;
        it.kind      = KIND_FMT;
        it.char_in   = c;
        it.arg_value = $urandom;
        it.arg_null  = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t num_arg(logic [31:0] v);
        in_item_t it;
        it.kind      = KIND_NUM;
        it.char_in   = 8'($urandom);
        it.arg_value = v;
        it.arg_null  = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t str_byte(logic [7:0] c, logic is_null);
        in_item_t it;
        it.kind      = KIND_STR;
        it.char_in   = c;
        it.arg_value = $urandom;
        it.arg_null  = is_null;
        return it;
    endfunction

    // Bias argument words toward the corners of the decimal conversion.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'($urandom_range(0, 9));
            4: return 32'($urandom_range(0, 999));
            default: return $urandom;
        endcase
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one item and hold it until the transfer. The gap, if any, is
    // spent with valid low; with no gap, valid stays high and only the
    // payload changes.
    task automatic send_item(in_item_t it, bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (counted) sent_items++;
    endtask

    task automatic send_spec(logic [7:0] spec);
        send_item(fmt_byte(CH_PERCENT), 1'b1);
        send_item(fmt_byte(spec), 1'b1);
    endtask

    // Drop valid and hold off until every predicted character has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Receiver: random stalls, mostly short, a few long; none while steady.
    initial begin
        int hold;
        int r;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin
        int             r;
        int             len;
        int             next_drain;
        logic [7:0]     c;
        logic [7:0]     spec;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        steady     = 1'b0;
        sent_items = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        send_item(fmt_byte("A"), 1'b1);
        send_item(fmt_byte(CH_TAB), 1'b1);          // tab from column one
        send_item(fmt_byte("\\"), 1'b1);            // backslash copies as is
        send_item(fmt_byte(8'hFF), 1'b1);
        send_spec(CH_LOW_D);
        send_item(num_arg(32'h8000_0000), 1'b1);    // most negative value
        send_spec(CH_LOW_U);
        send_item(num_arg(32'hFFFF_FFFF), 1'b1);
        send_item(num_arg(32'd7), 1'b0);            // argument in text: ignored
        send_item('{kind: 2'd3, char_in: 8'hA5, arg_value: 32'h5A5A_A5A5,
                    arg_null: 1'b1}, 1'b0);         // undefined kind: ignored
        send_spec(CH_PERCENT);                      // unknown specifier
        send_spec(CH_LOW_C);
        send_item(fmt_byte(CH_NUL), 1'b0);          // zero byte while waiting
        send_item(str_byte("z", 1'b0), 1'b0);       // string item for %c
        send_item(num_arg(32'h1234_5641), 1'b1);
        send_spec(CH_LOW_S);
        send_item(str_byte("h", 1'b0), 1'b1);
        send_item(num_arg(32'd1), 1'b0);            // numeric item for %s
        send_item(str_byte("i", 1'b1), 1'b1);       // null after one byte
        send_item(fmt_byte(CH_PERCENT), 1'b1);
        send_item(fmt_byte(CH_NUL), 1'b1);          // terminator after '%'

        // Sender waits for the output to run dry at least once.
        drain_results();
        next_drain = sent_items + 40;

        // Random part: mostly well-formed specifier sequences with random
        // content, some noise and stray items in between.
        while (sent_items < TEXT_ITEMS) begin
            if ($urandom_range(0, 11) == 0) steady = !steady;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_item(fmt_byte(8'($urandom_range(1, 255))), 1'b1);
            end else if (r < 45) begin
                send_item(fmt_byte(CH_TAB), 1'b1);
            end else if (r < 70) begin
                case ($urandom_range(0, 2))
                    0: spec = CH_LOW_D;
                    1: spec = CH_LOW_U;
                    default: spec = CH_LOW_C;
                endcase
                send_spec(spec);
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 1) send_item(fmt_byte(8'($urandom)), 1'b0);
                    else send_item(str_byte(8'($urandom), 1'($urandom)), 1'b0);
                end
                send_item(num_arg(pick_word()), 1'b1);
            end else if (r < 85) begin
                send_spec(CH_LOW_S);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    send_item(str_byte(8'($urandom_range(1, 255)), 1'b0), 1'b1);
                end
                if ($urandom_range(0, 9) == 0) send_item(num_arg($urandom), 1'b0);
                if ($urandom_range(0, 9) < 3) send_item(str_byte(8'($urandom), 1'b1), 1'b1);
                else send_item(str_byte(CH_NUL, 1'b0), 1'b1);
            end else if (r < 90) begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_LOW_D || c == CH_LOW_U || c == CH_LOW_C || c == CH_LOW_S);
                send_spec(c);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 3)) begin
                    send_item('{kind: 2'($urandom), char_in: 8'($urandom),
                                arg_value: $urandom, arg_null: 1'($urandom)}, 1'b0);
                end
            end else begin
                send_item(fmt_byte(CH_NUL), 1'b1);
            end

            if (sent_items >= next_drain) begin
                drain_results();
                next_drain = sent_items + 40 + $urandom_range(0, 20);
            end
        end

        // Let the last characters out, then give any stray ones time to show.
        drain_results();
        repeat (ARG_WIDTH + 16) @(negedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("format_string_text_formatter_tb: clean");
        end else begin
            $display("format_string_text_formatter_tb: errors");
        end
        $finish;
    end

endmodule
